>>> src/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared constants, types and helpers for the serial-bus frame decoder.
// ----------------------------------------------------------------------------
package sfd_pkg;

   // Counter width; outputs always show the low 16 bits
   localparam int COUNTER_WIDTH = 16;
   localparam int OUT_CNT_W     = 16;

   // Frame framing bytes
   localparam logic [7:0] START_BYTE = 8'h0F;
   localparam logic [7:0] END_BYTE   = 8'h00;

   // Frame geometry: 1 start byte, 22 data bytes, 1 flag byte, 1 end byte
   localparam int STORE_LEN = 24;
   localparam int DATA_LEN  = 22;
   localparam int FLAG_POS  = 23;   // receive position that holds the flag byte

   // Channel layout
   localparam int CHAN_W       = 11;
   localparam int NUM_ANALOG   = 16;
   localparam int LAST_CHANNEL = 17;
   localparam logic [CHAN_W-1:0] DIGITAL_ON = 11'h7FF;

   // Storage and bit-accumulator widths
   localparam int POS_W     = 5;
   localparam int ADDR_W    = 5;
   localparam int ACC_W     = 18;   // at most 10 leftover bits plus one byte
   localparam int ACC_CNT_W = 5;
   localparam int IDX_W     = 5;

   // Flag byte bits
   localparam int FLAG_CH16     = 0;
   localparam int FLAG_CH17     = 1;
   localparam int FLAG_LOST     = 2;
   localparam int FLAG_FAILSAFE = 3;

   typedef enum logic [1:0] {
      ST_RECV,
      ST_ERR,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic [IDX_W-1:0]     channel_index;
      logic [CHAN_W-1:0]    channel_value;
      logic                 failsafe_active;
      logic                 frame_lost_flag;
      logic                 frame_error;
      logic [OUT_CNT_W-1:0] error_count;
      logic [OUT_CNT_W-1:0] lost_count;
      logic                 last_of_frame;
   } rsp_type;

   // Show the low 16 bits of a counter, zero-extended when it is narrower
   function automatic logic [OUT_CNT_W-1:0] cnt_out(input logic [COUNTER_WIDTH-1:0] c);
      logic [COUNTER_WIDTH+OUT_CNT_W-1:0] w;
      begin
         w = (COUNTER_WIDTH+OUT_CNT_W)'(c);
         return w[OUT_CNT_W-1:0];
      end
   endfunction

endpackage

>>> src/sfd_stream_if.sv
// ----------------------------------------------------------------------------
// sfd_stream_if
// Valid/ready channels of the frame decoder: byte input and result output.
// ----------------------------------------------------------------------------
interface sfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_rsp_if import sfd_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> src/sbus_frame_decoder_unit.sv
// Sequence: the end byte moves the state register to the error or unload state;
//   an error result goes to the result register once it is free; a good frame
//   gives all 18 results, each store read added to the accumulator before the next.
// Throughput: one byte per cycle while receiving; no byte is taken while the
//   error result is loaded or the 18 results of a frame are unloaded.
// Reset: synchronous, active high; returns to idle, clears the failsafe flag and counters.
// ----------------------------------------------------------------------------
// sbus_frame_decoder_unit
// Collects 25-byte frames into a byte store, then unpacks sixteen 11-bit channels
// LSB first through a bit accumulator plus two digital channels; a bad end byte gives one error result.
// ----------------------------------------------------------------------------
module sbus_frame_decoder_unit import sfd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   sfd_req_if.sink   req_if,
   sfd_rsp_if.source rsp_if
);

   // Frame byte store; written while receiving, read while unloading, never both
   logic [7:0] mem [STORE_LEN];
   logic [7:0] rd_data_ff;
   logic       mem_we;
   logic       mem_re;
   logic [ADDR_W-1:0] wr_addr;

   state_type state_ff, state_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic [3:0]               flags_ff, flags_in;
   logic                     failsafe_ff, failsafe_in;
   logic                     lost_ff, lost_in;
   logic [COUNTER_WIDTH-1:0] err_cnt_ff, err_cnt_in;
   logic [COUNTER_WIDTH-1:0] lost_cnt_ff, lost_cnt_in;
   logic [ADDR_W-1:0]        rd_addr_ff, rd_addr_in;
   logic                     rd_pend_ff, rd_pend_in;
   logic [ACC_W-1:0]         acc_ff, acc_in;
   logic [ACC_CNT_W-1:0]     acc_cnt_ff, acc_cnt_in;
   logic [IDX_W-1:0]         chan_ff, chan_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic req_xfer;
   logic out_free;
   logic end_seen;
   logic end_ok;

   assign req_xfer = req_if.valid && req_if.ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign end_seen = req_xfer && (pos_ff == POS_W'(STORE_LEN));
   assign end_ok   = (req_if.rx_byte == END_BYTE);
   assign wr_addr  = ADDR_W'(pos_ff - POS_W'(1));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_RECV: begin
            if (end_seen) begin
               state_in = end_ok ? ST_DRAIN : ST_ERR;
            end
         end
         ST_ERR: begin
            if (out_free) begin
               state_in = ST_RECV;
            end
         end
         ST_DRAIN: begin
            if (out_free && chan_ff == IDX_W'(LAST_CHANNEL)) begin
               state_in = ST_RECV;
            end
         end
         default: begin
            state_in = ST_RECV;
         end
      endcase
   end

   // Handshake and store controls
   always_comb begin
      req_if.ready = (state_ff == ST_RECV);
      mem_we = req_xfer && (pos_ff != '0) && (pos_ff < POS_W'(STORE_LEN));
      mem_re = (state_ff == ST_DRAIN) && !rd_pend_ff
               && (acc_cnt_ff < ACC_CNT_W'(CHAN_W)) && (rd_addr_ff < ADDR_W'(DATA_LEN));
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

   // Datapath: receive position, counters, accumulator and result register
   always_comb begin
      pos_in       = pos_ff;
      flags_in     = flags_ff;
      failsafe_in  = failsafe_ff;
      lost_in      = lost_ff;
      err_cnt_in   = err_cnt_ff;
      lost_cnt_in  = lost_cnt_ff;
      rd_addr_in   = rd_addr_ff;
      rd_pend_in   = rd_pend_ff;
      acc_in       = acc_ff;
      acc_cnt_in   = acc_cnt_ff;
      chan_in      = chan_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // Drop the held result once it transfers
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_RECV: begin
            if (req_xfer) begin
               if (pos_ff == '0) begin
                  // Idle: wait for the start byte
                  if (req_if.rx_byte == START_BYTE) begin
                     pos_in = POS_W'(1);
                  end
               end else if (pos_ff < POS_W'(STORE_LEN)) begin
                  pos_in = pos_ff + POS_W'(1);
                  if (pos_ff == POS_W'(FLAG_POS)) begin
                     flags_in = req_if.rx_byte[3:0];
                  end
               end else begin
                  // End byte: judge the frame
                  pos_in = '0;
                  if (!end_ok) begin
                     if (err_cnt_ff != {COUNTER_WIDTH{1'b1}}) begin
                        err_cnt_in = err_cnt_ff + COUNTER_WIDTH'(1);
                     end
                  end else begin
                     failsafe_in = flags_ff[FLAG_FAILSAFE];
                     lost_in     = flags_ff[FLAG_LOST];
                     if (flags_ff[FLAG_LOST] && lost_cnt_ff != {COUNTER_WIDTH{1'b1}}) begin
                        lost_cnt_in = lost_cnt_ff + COUNTER_WIDTH'(1);
                     end
                     rd_addr_in = '0;
                     rd_pend_in = 1'b0;
                     acc_in     = '0;
                     acc_cnt_in = '0;
                     chan_in    = '0;
                  end
               end
            end
         end

         ST_ERR: begin
            // Load the single error result
            if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.channel_index   = '0;
               rsp_data_in.channel_value   = '0;
               rsp_data_in.failsafe_active = failsafe_ff;
               rsp_data_in.frame_lost_flag = 1'b0;
               rsp_data_in.frame_error     = 1'b1;
               rsp_data_in.error_count     = cnt_out(err_cnt_ff);
               rsp_data_in.lost_count      = cnt_out(lost_cnt_ff);
               rsp_data_in.last_of_frame   = 1'b1;
            end
         end

         ST_DRAIN: begin
            // Append returned store data above the leftover bits, or issue the next read
            if (rd_pend_ff) begin
               acc_in     = acc_ff | (ACC_W'(rd_data_ff) << acc_cnt_ff);
               acc_cnt_in = acc_cnt_ff + ACC_CNT_W'(8);
               rd_pend_in = 1'b0;
            end else if (mem_re) begin
               rd_pend_in = 1'b1;
               rd_addr_in = rd_addr_ff + ADDR_W'(1);
            end

            // Emit a channel when the result register is free
            rsp_data_in.failsafe_active = failsafe_ff;
            rsp_data_in.frame_lost_flag = lost_ff;
            rsp_data_in.frame_error     = 1'b0;
            rsp_data_in.error_count     = cnt_out(err_cnt_ff);
            rsp_data_in.lost_count      = cnt_out(lost_cnt_ff);
            rsp_data_in.channel_index   = chan_ff;
            rsp_data_in.last_of_frame   = (chan_ff == IDX_W'(LAST_CHANNEL));
            if (!out_free) begin
               rsp_data_in = rsp_data_ff;
            end else if (chan_ff < IDX_W'(NUM_ANALOG)) begin
               rsp_data_in.channel_value = acc_ff[CHAN_W-1:0];
               if (acc_cnt_ff >= ACC_CNT_W'(CHAN_W)) begin
                  rsp_valid_in = 1'b1;
                  acc_in       = acc_ff >> CHAN_W;
                  acc_cnt_in   = acc_cnt_ff - ACC_CNT_W'(CHAN_W);
                  chan_in      = chan_ff + IDX_W'(1);
               end else begin
                  rsp_data_in = rsp_data_ff;
               end
            end else begin
               rsp_valid_in = 1'b1;
               if (chan_ff == IDX_W'(NUM_ANALOG)) begin
                  rsp_data_in.channel_value = flags_ff[FLAG_CH16] ? DIGITAL_ON : '0;
               end else begin
                  rsp_data_in.channel_value = flags_ff[FLAG_CH17] ? DIGITAL_ON : '0;
               end
               chan_in = chan_ff + IDX_W'(1);
            end
         end

         default: begin
            pos_in = '0;
         end
      endcase
   end

   // Frame store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= req_if.rx_byte;
      end
      if (mem_re) begin
         rd_data_ff <= mem[rd_addr_ff];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RECV;
         pos_ff       <= '0;
         failsafe_ff  <= 1'b0;
         err_cnt_ff   <= '0;
         lost_cnt_ff  <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         failsafe_ff  <= failsafe_in;
         err_cnt_ff   <= err_cnt_in;
         lost_cnt_ff  <= lost_cnt_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      flags_ff    <= flags_in;
      lost_ff     <= lost_in;
      rd_addr_ff  <= rd_addr_in;
      acc_ff      <= acc_in;
      acc_cnt_ff  <= acc_cnt_in;
      chan_ff     <= chan_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> src/sfd_checker.sv
// ----------------------------------------------------------------------------
// sfd_checker
// Port-level checks of the frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module sfd_checker import sfd_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Clear the result channel and accept input after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("result valid or input blocked after reset");

   // An error result stands alone and closes its frame
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_error |->
         rsp_data.last_of_frame && rsp_data.channel_index == '0)
      else $error("malformed error result");

   // Only the final channel closes a good frame
   a_chan_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.frame_error |->
         (rsp_data.last_of_frame == (rsp_data.channel_index == IDX_W'(LAST_CHANNEL))))
      else $error("last marker on wrong channel");

   // Hold off input while a frame is still unloading
   a_no_input_mid_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_of_frame |-> !req_ready)
      else $error("input taken while frame results pending");

endmodule

bind sbus_frame_decoder_unit sfd_checker u_sfd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_data  (rsp_if.data)
);

>>> tb/sv/sbus_frame_decoder_unit_tb.sv
// ----------------------------------------------------------------------------
// sbus_frame_decoder_unit_tb
// Self-checking bench for the serial-bus frame decoder. It feeds byte streams
// made of stray bytes, good frames, frames with a bad end byte and cut-off
// frames, and predicts the channel results in the bench itself. Each result
// transfer is checked field by field against the oldest prediction, while both
// sides of the block idle at random over the first two thirds of the bytes.
// ----------------------------------------------------------------------------
module sbus_frame_decoder_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sfd_pkg::*;

   localparam int FRAME_BYTES    = STORE_LEN + 1;
   localparam int TOTAL_BYTES    = 240;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 70;

   // Shapes of the random byte sequences
   typedef enum logic [2:0] {
      SHAPE_GOOD,
      SHAPE_BAD_END,
      SHAPE_NOISE,
      SHAPE_CUT,
      SHAPE_EXTREME
   } shape_type;

   // One directed row: a single byte, or a whole frame with a typed result
   typedef struct packed {
      logic              is_frame;
      logic [7:0]        byte_val;   // stray byte, or fill of the data bytes
      logic              rnd_data;
      logic [7:0]        flags;
      logic [7:0]        end_b;
      logic              typed;
      logic              x_err;
      logic [CHAN_W-1:0] x_analog;
      logic [CHAN_W-1:0] x_ch16;
      logic [CHAN_W-1:0] x_ch17;
      logic              x_fs;
      logic              x_lost;
      logic [15:0]       x_errs;
      logic [15:0]       x_losts;
   } stim_row_type;

   logic clock;
   logic reset;

   sfd_req_if req_if ();
   sfd_rsp_if rsp_if ();

   sbus_frame_decoder_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   stim_row_type directed_rows [13] = '{
      // stray bytes while idle
      '{1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0,
        11'd0, 11'd0, 11'd0, 1'b0, 1'b0, 16'd0, 16'd0},
      '{1'b0, 8'hFF, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0,
        11'd0, 11'd0, 11'd0, 1'b0, 1'b0, 16'd0, 16'd0},
      '{1'b0, 8'hF0, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0,
        11'd0, 11'd0, 11'd0, 1'b0, 1'b0, 16'd0, 16'd0},
      // all-zero frame
      '{1'b1, 8'h00, 1'b0, 8'h00, 8'h00, 1'b1, 1'b0,
        11'd0, 11'd0, 11'd0, 1'b0, 1'b0, 16'd0, 16'd0},
      // all-ones data, every low flag bit set
      '{1'b1, 8'hFF, 1'b0, 8'h0F, 8'h00, 1'b1, 1'b0,
        11'd2047, 11'd2047, 11'd2047, 1'b1, 1'b1, 16'd0, 16'd1},
      // bad end byte keeps failsafe and lost count
      '{1'b1, 8'hAA, 1'b0, 8'h0C, 8'h01, 1'b1, 1'b1,
        11'd0, 11'd0, 11'd0, 1'b1, 1'b0, 16'd1, 16'd1},
      // alternating bits, channel 16 only
      '{1'b1, 8'h55, 1'b0, 8'h01, 8'h00, 1'b0, 1'b0,
        11'd0, 11'd0, 11'd0, 1'b0, 1'b0, 16'd0, 16'd0},
      // start byte as data, upper flag bits set
      '{1'b1, 8'h0F, 1'b0, 8'hF2, 8'h00, 1'b0, 1'b0,
        11'd0, 11'd0, 11'd0, 1'b0, 1'b0, 16'd0, 16'd0},
      '{1'b1, 8'h00, 1'b1, 8'h08, 8'h80, 1'b0, 1'b0,
        11'd0, 11'd0, 11'd0, 1'b0, 1'b0, 16'd0, 16'd0},
      '{1'b1, 8'h00, 1'b1, 8'h04, 8'h00, 1'b0, 1'b0,
        11'd0, 11'd0, 11'd0, 1'b0, 1'b0, 16'd0, 16'd0},
      '{1'b0, 8'h0E, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0,
        11'd0, 11'd0, 11'd0, 1'b0, 1'b0, 16'd0, 16'd0},
      '{1'b1, 8'hFF, 1'b0, 8'h00, 8'hFF, 1'b1, 1'b1,
        11'd0, 11'd0, 11'd0, 1'b0, 1'b0, 16'd3, 16'd2},
      // zero data, all flag bits set
      '{1'b1, 8'h00, 1'b0, 8'hFF, 8'h00, 1'b1, 1'b0,
        11'd0, 11'd2047, 11'd2047, 1'b1, 1'b1, 16'd3, 16'd3}
   };

   int src_idle_pct;
   int snk_idle_pct;
   int fail_count;
   int checked_count;
   int byte_count;
   int good_frames;
   int bad_frames;
   int stall_cycles;
   bit predict_quiet;   // results of the current row are typed in

   // Decoder model state
   int unsigned              frame_pos;
   logic [7:0]               frame_store [STORE_LEN];
   logic                     failsafe_q;
   logic [COUNTER_WIDTH-1:0] bad_end_q;
   logic [COUNTER_WIDTH-1:0] lost_frame_q;
   rsp_type                  pending_channels [$];

   // Clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic rsp_type make_channel(input logic [IDX_W-1:0] idx,
                                            input logic [CHAN_W-1:0] val,
                                            input logic fs, input logic lost,
                                            input logic err,
                                            input logic [OUT_CNT_W-1:0] errs,
                                            input logic [OUT_CNT_W-1:0] losts,
                                            input logic last);
      rsp_type r;
      r.channel_index   = idx;
      r.channel_value   = val;
      r.failsafe_active = fs;
      r.frame_lost_flag = lost;
      r.frame_error     = err;
      r.error_count     = errs;
      r.lost_count      = losts;
      r.last_of_frame   = last;
      return r;
   endfunction

   // Advance the decoder model by one byte and queue the channels it gives
   function void decode_rx_byte(input logic [7:0] b);
      logic [DATA_LEN*8-1:0] data_bits;
      logic [7:0]            flags;
      logic                  lost;
      if (frame_pos == 0) begin
         if (b == START_BYTE) frame_pos = 1;
         return;
      end
      frame_store[ADDR_W'(frame_pos - 1)] = b;
      frame_pos++;
      if (frame_pos < FRAME_BYTES) return;
      frame_pos = 0;

      // bad end byte: one error result, failsafe and lost count held
      if (frame_store[STORE_LEN-1] != END_BYTE) begin
         if (bad_end_q != '1) bad_end_q++;
         bad_frames++;
         if (!predict_quiet)
            pending_channels.push_back(make_channel('0, '0, failsafe_q, 1'b0, 1'b1,
               OUT_CNT_W'(bad_end_q), OUT_CNT_W'(lost_frame_q), 1'b1));
         return;
      end

      flags      = frame_store[FLAG_POS-1];
      lost       = flags[FLAG_LOST];
      failsafe_q = flags[FLAG_FAILSAFE];
      if (lost && lost_frame_q != '1) lost_frame_q++;
      good_frames++;
      if (predict_quiet) return;

      // data bytes form one LSB-first bit string of sixteen 11-bit channels
      for (int i = 0; i < DATA_LEN; i++) data_bits[i*8 +: 8] = frame_store[ADDR_W'(i)];
      for (int k = 0; k < NUM_ANALOG; k++)
         pending_channels.push_back(make_channel(IDX_W'(k), data_bits[k*CHAN_W +: CHAN_W],
            failsafe_q, lost, 1'b0, OUT_CNT_W'(bad_end_q), OUT_CNT_W'(lost_frame_q), 1'b0));
      pending_channels.push_back(make_channel(IDX_W'(NUM_ANALOG),
         flags[FLAG_CH16] ? DIGITAL_ON : '0, failsafe_q, lost, 1'b0,
         OUT_CNT_W'(bad_end_q), OUT_CNT_W'(lost_frame_q), 1'b0));
      pending_channels.push_back(make_channel(IDX_W'(LAST_CHANNEL),
         flags[FLAG_CH17] ? DIGITAL_ON : '0, failsafe_q, lost, 1'b0,
         OUT_CNT_W'(bad_end_q), OUT_CNT_W'(lost_frame_q), 1'b1));
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   function void check_channel(input rsp_type got);
      rsp_type want;
      if (pending_channels.size() == 0) begin
         $display("%0t ns: unexpected result, expected none, actual channel %0d value %0d",
                  $time, got.channel_index, got.channel_value);
         fail_count++;
         return;
      end
      want = pending_channels.pop_front();
      checked_count++;
      check_field("channel_index", 32'(want.channel_index), 32'(got.channel_index));
      check_field("channel_value", 32'(want.channel_value), 32'(got.channel_value));
      check_field("failsafe_active", 32'(want.failsafe_active), 32'(got.failsafe_active));
      check_field("frame_lost_flag", 32'(want.frame_lost_flag), 32'(got.frame_lost_flag));
      check_field("frame_error", 32'(want.frame_error), 32'(got.frame_error));
      check_field("error_count", 32'(want.error_count), 32'(got.error_count));
      check_field("lost_count", 32'(want.lost_count), 32'(got.lost_count));
      check_field("last_of_frame", 32'(want.last_of_frame), 32'(got.last_of_frame));
   endfunction

   // Sample both channels mid-cycle: what holds here transfers at the next edge
   always @(negedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) decode_rx_byte(req_if.rx_byte);
         if (rsp_if.valid && rsp_if.ready) check_channel(rsp_if.data);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles", $time, stall_cycles);
            $display("tb: failure");
            $finish;
         end
      end
   end

   // Result side: stall at random
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
   end

   // Offer one byte, with random idle cycles ahead; return at the transfer edge
   task automatic send_byte(input logic [7:0] b);
      // Pick the idle mix by how far the run has come
      if (byte_count >= 2 * TOTAL_BYTES / 3) begin
         src_idle_pct = 0;
         snk_idle_pct = 0;
      end else if (byte_count >= TOTAL_BYTES / 3) begin
         src_idle_pct = 66;
         snk_idle_pct = 25;
      end
      while ($urandom_range(99) < src_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.rx_byte <= b;
      @(negedge clock);
      while (!req_if.ready) @(negedge clock);
      @(posedge clock);
      byte_count++;
   endtask

   task automatic send_frame(input logic [DATA_LEN*8-1:0] payload, input logic [7:0] flags,
                             input logic [7:0] end_b);
      send_byte(START_BYTE);
      for (int i = 0; i < DATA_LEN; i++) send_byte(payload[i*8 +: 8]);
      send_byte(flags);
      send_byte(end_b);
   endtask

   initial begin
      stim_row_type          row;
      logic [DATA_LEN*8-1:0] payload;
      shape_type             shape;
      int                    pick;
      int                    n;

      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.rx_byte <= 8'h00;
      frame_pos      = 0;
      failsafe_q     = 1'b0;
      bad_end_q      = '0;
      lost_frame_q   = '0;
      src_idle_pct   = 25;
      snk_idle_pct   = 66;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed rows: typed results where the row is plain to read
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (!row.is_frame) begin
            send_byte(row.byte_val);
         end else begin
            predict_quiet = row.typed;
            if (row.typed && row.x_err) begin
               pending_channels.push_back(make_channel('0, '0, row.x_fs, 1'b0, 1'b1,
                  row.x_errs, row.x_losts, 1'b1));
            end else if (row.typed) begin
               for (int k = 0; k < NUM_ANALOG; k++)
                  pending_channels.push_back(make_channel(IDX_W'(k), row.x_analog, row.x_fs,
                     row.x_lost, 1'b0, row.x_errs, row.x_losts, 1'b0));
               pending_channels.push_back(make_channel(IDX_W'(NUM_ANALOG), row.x_ch16,
                  row.x_fs, row.x_lost, 1'b0, row.x_errs, row.x_losts, 1'b0));
               pending_channels.push_back(make_channel(IDX_W'(LAST_CHANNEL), row.x_ch17,
                  row.x_fs, row.x_lost, 1'b0, row.x_errs, row.x_losts, 1'b1));
            end
            for (int j = 0; j < DATA_LEN; j++)
               payload[j*8 +: 8] = row.rnd_data ? 8'($urandom) : row.byte_val;
            send_frame(payload, row.flags, row.end_b);
            predict_quiet = 1'b0;
         end
      end

      // Random part: mostly good frames, some bad, cut-off and stray bytes
      while (byte_count < TOTAL_BYTES) begin
         pick = $urandom_range(9);
         if (pick <= 5)      shape = SHAPE_GOOD;
         else if (pick == 6) shape = SHAPE_BAD_END;
         else if (pick == 7) shape = SHAPE_NOISE;
         else if (pick == 8) shape = SHAPE_CUT;
         else                shape = SHAPE_EXTREME;
         for (int j = 0; j < DATA_LEN; j++) payload[j*8 +: 8] = 8'($urandom);
         case (shape)
            SHAPE_GOOD: begin
               send_frame(payload, 8'($urandom), END_BYTE);
            end
            SHAPE_BAD_END: begin
               send_frame(payload, 8'($urandom), 8'($urandom_range(255, 1)));
            end
            SHAPE_NOISE: begin
               n = $urandom_range(4, 1);
               repeat (n) send_byte(8'($urandom));
            end
            SHAPE_CUT: begin
               // the frame swallows whatever follows it
               n = $urandom_range(STORE_LEN - 1, 1);
               send_byte(START_BYTE);
               repeat (n) send_byte(8'($urandom));
            end
            default: begin
               for (int j = 0; j < DATA_LEN; j++)
                  payload[j*8 +: 8] = ($urandom_range(2) == 0) ? 8'h00 :
                                      ($urandom_range(1) == 0) ? 8'hFF : 8'($urandom);
               send_frame(payload, 8'($urandom), END_BYTE);
            end
         endcase
      end
      req_if.valid <= 1'b0;

      // Drain outstanding results, then give stray results time to show up
      while (pending_channels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb: %0d bytes sent, %0d good and %0d bad-end frames decoded",
               byte_count, good_frames, bad_frames);
      $display("tb: %0d results checked, %0d mismatches", checked_count, fail_count);
      if (fail_count == 0 && pending_channels.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
